// ----- rtl/core/rvde_pkg.sv -----
// Package: opcodes, operation classes and decode control types for the decode/execute stage.
`default_nettype none
package rvde_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned OP_CLASS_W = 3;

    localparam logic [6:0] OPC_ADD   = 7'h33;
    localparam logic [6:0] OPC_ADDI  = 7'h13;
    localparam logic [6:0] OPC_LW    = 7'h03;
    localparam logic [6:0] OPC_SW    = 7'h23;
    localparam logic [6:0] OPC_BLT   = 7'h63;
    localparam logic [6:0] OPC_AUIPC = 7'h17;
    localparam logic [6:0] OPC_JAL   = 7'h6F;

    localparam logic [OP_CLASS_W-1:0] CLS_UNKNOWN = 3'd0;
    localparam logic [OP_CLASS_W-1:0] CLS_ADD     = 3'd1;
    localparam logic [OP_CLASS_W-1:0] CLS_ADDI    = 3'd2;
    localparam logic [OP_CLASS_W-1:0] CLS_LW      = 3'd3;
    localparam logic [OP_CLASS_W-1:0] CLS_SW      = 3'd4;
    localparam logic [OP_CLASS_W-1:0] CLS_BLT     = 3'd5;
    localparam logic [OP_CLASS_W-1:0] CLS_AUIPC   = 3'd6;
    localparam logic [OP_CLASS_W-1:0] CLS_JAL     = 3'd7;

    localparam logic [XLEN-1:0] LINK_OFFSET = 32'd4;

    typedef struct packed {
        logic [OP_CLASS_W-1:0] op_class;
        logic                  rd_write;
        logic                  is_load;
        logic                  store_op;
    } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/rvde_in_if.sv -----
// Interface: instruction item channel into the decode/execute stage.
`default_nettype none
interface rvde_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] inst_addr;
    logic [31:0] src1_value;
    logic [31:0] src2_value;

    modport source (
        output valid, instruction, inst_addr, src1_value, src2_value,
        input  ready
    );
    modport sink (
        input  valid, instruction, inst_addr, src1_value, src2_value,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/rvde_out_if.sv -----
// Interface: result item channel out of the decode/execute stage.
`default_nettype none
interface rvde_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] exec_result;
    logic signed [31:0] immediate;
    logic        [31:0] store_value;
    logic        [4:0]  dest_reg;
    logic        [4:0]  src1_reg;
    logic        [4:0]  src2_reg;
    logic        [2:0]  op_class;
    logic               rd_write;
    logic               is_load;
    logic               store_op;

    modport source (
        output valid, exec_result, immediate, store_value, dest_reg, src1_reg, src2_reg,
               op_class, rd_write, is_load, store_op,
        input  ready
    );
    modport sink (
        input  valid, exec_result, immediate, store_value, dest_reg, src1_reg, src2_reg,
               op_class, rd_write, is_load, store_op,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/core/rvde_decode.sv -----
// Decoder: opcode classification, control flags and immediate reconstruction.
`default_nettype none
module rvde_decode (
    input  wire logic [31:0]    instruction,
    output rvde_pkg::ctrl_t     ctrl,
    output logic signed [31:0]  immediate
);
    import rvde_pkg::*;

    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_u = {instruction[31:12], 12'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};

    always_comb
    begin
        ctrl      = '0;
        immediate = '0;
        case (instruction[6:0])
            OPC_ADD:
            begin
                ctrl.op_class  = CLS_ADD;
                ctrl.rd_write  = 1'b1;
            end
            OPC_ADDI:
            begin
                ctrl.op_class  = CLS_ADDI;
                ctrl.rd_write  = 1'b1;
                immediate      = $signed(imm_i);
            end
            OPC_LW:
            begin
                ctrl.op_class  = CLS_LW;
                ctrl.rd_write  = 1'b1;
                ctrl.is_load   = 1'b1;
                immediate      = $signed(imm_i);
            end
            OPC_SW:
            begin
                ctrl.op_class  = CLS_SW;
                ctrl.store_op  = 1'b1;
                immediate      = $signed(imm_s);
            end
            OPC_BLT:
            begin
                ctrl.op_class  = CLS_BLT;
                immediate      = $signed(imm_b);
            end
            OPC_AUIPC:
            begin
                ctrl.op_class  = CLS_AUIPC;
                ctrl.rd_write  = 1'b1;
                immediate      = $signed(imm_u);
            end
            OPC_JAL:
            begin
                ctrl.op_class  = CLS_JAL;
                ctrl.rd_write  = 1'b1;
                immediate      = $signed(imm_j);
            end
            default:
            begin
                ctrl      = '0;
                immediate = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/rvde_alu.sv -----
// ALU: sums, effective addresses, signed compare and pc-relative results.
`default_nettype none
module rvde_alu (
    input  wire rvde_pkg::ctrl_t    ctrl,
    input  wire logic [31:0]        inst_addr,
    input  wire logic [31:0]        src1_value,
    input  wire logic [31:0]        src2_value,
    input  wire logic signed [31:0] immediate,
    output logic [31:0]             exec_result
);
    import rvde_pkg::*;

    logic [31:0] imm_u;
    logic        lt_signed;

    assign imm_u     = $unsigned(immediate);
    assign lt_signed = $signed(src1_value) < $signed(src2_value);

    always_comb
    begin
        case (ctrl.op_class)
            CLS_ADD:   exec_result = src1_value + src2_value;
            CLS_ADDI,
            CLS_LW,
            CLS_SW:    exec_result = src1_value + imm_u;
            CLS_BLT:   exec_result = {31'b0, lt_signed};
            CLS_AUIPC: exec_result = inst_addr + imm_u;
            CLS_JAL:   exec_result = inst_addr + LINK_OFFSET;
            default:   exec_result = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/rv32_subset_decode_execute.sv -----
// Top level: registered decode/execute stage for an RV32 instruction subset.
`default_nettype none
// Decodes add, addi, lw, sw, blt, auipc and jal by opcode alone (funct3 and
// funct7 are not examined) and returns one result item per instruction item.
// Items pass an input register and then a result register, with the decoder and
// ALU combinational between the two, and one item is taken every cycle while
// the result side keeps up. blt compares as signed. Unknown opcodes give a
// zero result, zero immediate and no flags, while register indices and the
// store value still pass through.
module rv32_subset_decode_execute (
    input wire logic clk,
    input wire logic rst_n,
    rvde_in_if.sink    issue,
    rvde_out_if.source result
);
    import rvde_pkg::*;

    logic        s1_valid_reg;
    logic [31:0] s1_instr_reg;
    logic [31:0] s1_addr_reg;
    logic [31:0] s1_src1_reg;
    logic [31:0] s1_src2_reg;

    logic               out_valid_reg;
    logic [31:0]        exec_result_reg;
    logic signed [31:0] immediate_reg;
    logic [31:0]        store_value_reg;
    logic [4:0]         dest_reg_reg;
    logic [4:0]         src1_idx_reg;
    logic [4:0]         src2_idx_reg;
    ctrl_t              ctrl_reg;

    ctrl_t              ctrl_next;
    logic signed [31:0] immediate_next;
    logic [31:0]        exec_result_next;

    logic s2_ready;
    logic s1_ready;

    assign s2_ready    = !out_valid_reg || result.ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign issue.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && issue.valid)
        begin
            s1_instr_reg <= issue.instruction;
            s1_addr_reg  <= issue.inst_addr;
            s1_src1_reg  <= issue.src1_value;
            s1_src2_reg  <= issue.src2_value;
        end
    end

    rvde_decode u_decode (
        .instruction (s1_instr_reg),
        .ctrl        (ctrl_next),
        .immediate   (immediate_next)
    );

    rvde_alu u_alu (
        .ctrl        (ctrl_next),
        .inst_addr   (s1_addr_reg),
        .src1_value  (s1_src1_reg),
        .src2_value  (s1_src2_reg),
        .immediate   (immediate_next),
        .exec_result (exec_result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            exec_result_reg <= exec_result_next;
            immediate_reg   <= immediate_next;
            store_value_reg <= s1_src2_reg;
            dest_reg_reg    <= s1_instr_reg[11:7];
            src1_idx_reg    <= s1_instr_reg[19:15];
            src2_idx_reg    <= s1_instr_reg[24:20];
            ctrl_reg        <= ctrl_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.exec_result = exec_result_reg;
    assign result.immediate   = immediate_reg;
    assign result.store_value = store_value_reg;
    assign result.dest_reg    = dest_reg_reg;
    assign result.src1_reg    = src1_idx_reg;
    assign result.src2_reg    = src2_idx_reg;
    assign result.op_class    = ctrl_reg.op_class;
    assign result.rd_write    = ctrl_reg.rd_write;
    assign result.is_load     = ctrl_reg.is_load;
    assign result.store_op    = ctrl_reg.store_op;
endmodule
`default_nettype wire
